// ===== rtl/fnpll_pkg.sv =====
// Package: shared types, constants and widths of the fractional-N PLL register calculator.
`timescale 1ns / 1ps
package fnpll_pkg;

  // Frequency limits in kHz
  localparam int unsigned FreqMaxKhz = 4400000;
  localparam int unsigned FreqMinKhz = 35;
  localparam int unsigned FreqW      = 23;  // clamped frequency width
  localparam int unsigned ExpoW      = 5;   // divider exponent 1..16
  localparam int unsigned ExpoMax    = 16;
  localparam int unsigned NumW       = 24;  // f << expo stays below 2^24
  localparam int unsigned DenW       = 18;  // pfd * 1000 <= 255000
  localparam int unsigned NintW      = 14;
  localparam int unsigned ModW       = 16;

  // Serial divider widths
  localparam int unsigned DivDW   = 35;
  localparam int unsigned DivSW   = 19;
  localparam int unsigned DivCntW = 6;

  // Bit counts per division kind
  localparam logic [DivCntW-1:0] NumBits = DivCntW'(NumW);
  localparam logic [DivCntW-1:0] RndBits = DivCntW'(DivDW);
  localparam logic [DivCntW-1:0] GcdBits = DivCntW'(ModW);

  // Default depth of the queue between front and back
  localparam int unsigned FifoDepthDef = 2;

  // Configuration register indexes
  localparam logic [2:0] CfgPfd   = 3'd0;
  localparam logic [2:0] CfgMod   = 3'd1;
  localparam logic [2:0] CfgReg2  = 3'd2;
  localparam logic [2:0] CfgReg3  = 3'd3;
  localparam logic [2:0] CfgReg5  = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  PfdRst  = 8'd25;
  localparam logic [15:0] ModRst  = 16'd25000;
  localparam logic [31:0] Reg2Rst = 32'h0000_4E42;
  localparam logic [31:0] Reg3Rst = 32'h0000_04B3;
  localparam logic [31:0] Reg5Rst = 32'h0058_0005;

  // Beat positions in send order
  localparam logic [2:0] BeatReg5 = 3'd0;
  localparam logic [2:0] BeatReg4 = 3'd1;
  localparam logic [2:0] BeatReg3 = 3'd2;
  localparam logic [2:0] BeatReg2 = 3'd3;
  localparam logic [2:0] BeatReg1 = 3'd4;
  localparam logic [2:0] BeatReg0 = 3'd5;

  // Fixed word parts
  localparam logic [31:0] Reg1Base = (32'd1 << 27) + (32'd1 << 15) + 32'd1;
  localparam logic [31:0] Reg4Base = (32'd1 << 23) + (32'd200 << 12) + (32'd1 << 5)
                                     + (32'd3 << 3) + 32'd4;

  typedef struct packed {
    logic [1:0]  channel;
    logic [23:0] freq_khz;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target_channel;
    logic [31:0] reg_word;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  pfd_mhz;
    logic [15:0] modulus_base;
    logic [31:0] reg2_word;
    logic [31:0] reg3_word;
    logic [31:0] reg5_word;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [1:0]       channel;
    logic [FreqW-1:0] freq;
    logic [ExpoW-1:0] expo;
  } job_t;

  typedef struct packed {
    logic               start;
    logic [DivDW-1:0]   dividend;
    logic [DivSW-1:0]   divisor;
    logic [DivCntW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivDW-1:0] quot;
    logic [DivSW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NUM,
    BK_NUM_W,
    BK_MUL,
    BK_RND,
    BK_RND_W,
    BK_GCD,
    BK_GCD_W,
    BK_FRAC,
    BK_FRAC_W,
    BK_MOD,
    BK_MOD_W,
    BK_EMIT
  } bk_state_e;

endpackage

// ===== rtl/fnpll_front.sv =====
// Front end: accept beats, clamp frequency, find divider exponent, queue jobs.
`timescale 1ns / 1ps
module fnpll_front #(
  parameter int unsigned FifoDepth = fnpll_pkg::FifoDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  fnpll_pkg::in_item_t item_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output fnpll_pkg::job_t    job_o
);
  import fnpll_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FifoDepth);

  logic [FreqW-1:0] freq_c;
  logic [ExpoW-1:0] expo_c;
  job_t             job_c;

  job_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  // Clamp to the legal range
  always_comb begin
    if (item_i.freq_khz > 24'(FreqMaxKhz)) begin
      freq_c = FreqW'(FreqMaxKhz);
    end else if (item_i.freq_khz < 24'(FreqMinKhz)) begin
      freq_c = FreqW'(FreqMinKhz);
    end else begin
      freq_c = item_i.freq_khz[FreqW-1:0];
    end
  end

  // Smallest exponent with f * 2^(i+1) above the maximum; lowest match wins
  always_comb begin
    logic [FreqW+ExpoMax:0] sh;
    expo_c = ExpoW'(ExpoMax);
    for (int i = ExpoMax; i >= 1; i--) begin
      sh = (FreqW+ExpoMax+1)'(freq_c) << (i + 1);
      if (sh > (FreqW+ExpoMax+1)'(FreqMaxKhz)) begin
        expo_c = ExpoW'(i);
      end
    end
  end

  always_comb begin
    job_c.channel = item_i.channel;
    job_c.freq    = freq_c;
    job_c.expo    = expo_c;
  end

  assign full        = (cnt_q == CntFull);
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = job_valid_o && job_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= job_c;
    end
  end

endmodule

// ===== rtl/fnpll_div.sv =====
// Restoring serial divider, one quotient bit per cycle, selectable bit count.
`timescale 1ns / 1ps
module fnpll_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fnpll_pkg::div_req_t req_i,
  output fnpll_pkg::div_rsp_t rsp_o
);
  import fnpll_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivSW-1:0]   rem_q, rem_d;
  logic [DivSW-1:0]   dvs_q;
  logic [DivDW-1:0]   sh_q, sh_d;
  logic [DivSW:0]     trial;
  logic               ge;

  assign trial = {rem_q, sh_q[DivDW-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d = ge ? DivSW'(trial - {1'b0, dvs_q}) : trial[DivSW-1:0];
    sh_d  = {sh_q[DivDW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Align the dividend so its top used bit enters first
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      sh_q  <= req_i.dividend << (DivCntW'(DivDW) - req_i.nbits);
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/fnpll_back.sv =====
// Back end: sequence divisions and Euclid steps, then send the six register words.
`timescale 1ns / 1ps
module fnpll_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fnpll_pkg::cfg_t      cfg_i,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  fnpll_pkg::job_t      job_i,
  output fnpll_pkg::div_req_t  div_req_o,
  input  fnpll_pkg::div_rsp_t  div_rsp_i,
  output logic                 empty,
  input  logic                 pop,
  output fnpll_pkg::out_item_t result_o
);
  import fnpll_pkg::*;

  bk_state_e state_q, state_d;

  logic [1:0]       ch_q;
  logic [FreqW-1:0] freq_q;
  logic [ExpoW-1:0] expo_q;
  logic [NintW-1:0] nint_q;
  logic [DenW-1:0]  rem_q;
  logic [33:0]      prod_q;
  logic [ModW-1:0]  nfrac_q, a_q, b_q, frac_q, mod_q;
  logic [2:0]       beat_q;

  logic [7:0]       pfd_eff;
  logic [DenW-1:0]  den;
  logic [NumW-1:0]  num;
  logic [ModW-1:0]  div_q16, div_r16;
  logic [31:0]      w0, w1, w4;
  logic             beat_done;

  assign pfd_eff   = (cfg_i.pfd_mhz == '0) ? 8'd1 : cfg_i.pfd_mhz;
  assign den       = DenW'(pfd_eff) * DenW'(1000);
  assign num       = NumW'((NumW + ExpoMax)'(freq_q) << expo_q);
  assign div_q16   = div_rsp_i.quot[ModW-1:0];
  assign div_r16   = div_rsp_i.rem[ModW-1:0];
  assign beat_done = pop && !empty;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (job_valid_i) state_d = BK_NUM;
      BK_NUM:    state_d = BK_NUM_W;
      BK_NUM_W:  if (div_rsp_i.done) state_d = BK_MUL;
      BK_MUL:    state_d = BK_RND;
      BK_RND:    state_d = BK_RND_W;
      BK_RND_W: begin
        if (div_rsp_i.done) begin
          state_d = (div_q16 == '0) ? BK_EMIT : BK_GCD;
        end
      end
      BK_GCD:    state_d = BK_GCD_W;
      BK_GCD_W: begin
        if (div_rsp_i.done) begin
          state_d = (div_r16 == '0) ? BK_FRAC : BK_GCD;
        end
      end
      BK_FRAC:   state_d = BK_FRAC_W;
      BK_FRAC_W: if (div_rsp_i.done) state_d = BK_MOD;
      BK_MOD:    state_d = BK_MOD_W;
      BK_MOD_W:  if (div_rsp_i.done) state_d = BK_EMIT;
      BK_EMIT:   if (beat_done && beat_q == BeatReg0) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Outputs: divider requests and handshakes
  always_comb begin
    div_req_o   = '0;
    job_ready_o = 1'b0;
    empty       = 1'b1;
    unique case (state_q)
      BK_IDLE: job_ready_o = 1'b1;
      BK_NUM: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivDW'(num);
        div_req_o.divisor  = DivSW'(den);
        div_req_o.nbits    = NumBits;
      end
      BK_RND: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivDW'({prod_q, 1'b0}) + DivDW'(den);
        div_req_o.divisor  = {den, 1'b0};
        div_req_o.nbits    = RndBits;
      end
      BK_GCD: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivDW'(a_q);
        div_req_o.divisor  = DivSW'(b_q);
        div_req_o.nbits    = GcdBits;
      end
      BK_FRAC: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivDW'(nfrac_q);
        div_req_o.divisor  = DivSW'(b_q);
        div_req_o.nbits    = GcdBits;
      end
      BK_MOD: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = DivDW'(cfg_i.modulus_base);
        div_req_o.divisor  = DivSW'(b_q);
        div_req_o.nbits    = GcdBits;
      end
      BK_EMIT: empty = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      beat_q  <= BeatReg5;
    end else begin
      state_q <= state_d;
      if (state_q == BK_IDLE) begin
        beat_q <= BeatReg5;
      end else if (beat_done) begin
        beat_q <= beat_q + 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        ch_q   <= job_i.channel;
        freq_q <= job_i.freq;
        expo_q <= job_i.expo;
      end
      BK_NUM_W: begin
        nint_q <= div_rsp_i.quot[NintW-1:0];
        rem_q  <= div_rsp_i.rem[DenW-1:0];
      end
      BK_MUL: prod_q <= 34'(cfg_i.modulus_base) * 34'(rem_q);
      BK_RND_W: begin
        nfrac_q <= div_q16;
        a_q     <= cfg_i.modulus_base;
        b_q     <= div_q16;
        frac_q  <= '0;
        mod_q   <= ModW'(2);
      end
      BK_GCD_W: begin
        if (div_rsp_i.done && div_r16 != '0) begin
          a_q <= b_q;
          b_q <= div_r16;
        end
      end
      BK_FRAC_W: frac_q <= div_q16;
      BK_MOD_W:  mod_q  <= (div_q16 == ModW'(1)) ? ModW'(2) : div_q16;
      default: ;
    endcase
  end

  assign w0 = (32'(nint_q) << 15) + (32'(frac_q) << 3);
  assign w1 = Reg1Base + (32'(mod_q) << 3);
  assign w4 = Reg4Base + (32'(expo_q) << 20);

  always_comb begin
    result_o.target_channel = ch_q;
    result_o.last_word      = (beat_q == BeatReg0);
    case (beat_q)
      BeatReg5: result_o.reg_word = cfg_i.reg5_word;
      BeatReg4: result_o.reg_word = w4;
      BeatReg3: result_o.reg_word = cfg_i.reg3_word;
      BeatReg2: result_o.reg_word = cfg_i.reg2_word;
      BeatReg1: result_o.reg_word = w1;
      default:  result_o.reg_word = w0;
    endcase
  end

endmodule

// ===== rtl/frac_n_pll_register_calc_core.sv =====
// Top level: fractional-N PLL register word calculator with configuration registers.
//
//  channel   direction  handshake                  beat payload
//  -------   ---------  -------------------------  -------------------------------------
//  input     in         push / full                channel, freq_khz
//  result    out        empty / pop                target_channel, reg_word, last_word
//  config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each input beat yields six result beats, reg5 first and reg0 last. For each job the
// back end takes the job, divides for the integer part, multiplies and divides to round;
// a nonzero fraction adds the Euclid divisions and two more that reduce the fraction and
// the modulus. Then the six words are popped; a stalled pop holds the current word.
// The front queue takes input beats until full while the back end works or stalls.
// Reset loads the configuration defaults and empties the queue; no clearing pass.
`timescale 1ns / 1ps
module frac_n_pll_register_calc_core #(
  parameter int unsigned FifoDepth = fnpll_pkg::FifoDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  fnpll_pkg::in_item_t   item_i,
  output logic                  empty,
  input  logic                  pop,
  output fnpll_pkg::out_item_t  result_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);
  import fnpll_pkg::*;

  cfg_t     cfg_q;
  logic     job_valid, job_ready;
  job_t     job;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Configuration writes are always taken; unknown indexes drop the beat
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pfd_mhz      <= PfdRst;
      cfg_q.modulus_base <= ModRst;
      cfg_q.reg2_word    <= Reg2Rst;
      cfg_q.reg3_word    <= Reg3Rst;
      cfg_q.reg5_word    <= Reg5Rst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgPfd:  cfg_q.pfd_mhz      <= cfg_data_i[7:0];
        CfgMod:  cfg_q.modulus_base <= cfg_data_i[15:0];
        CfgReg2: cfg_q.reg2_word    <= cfg_data_i;
        CfgReg3: cfg_q.reg3_word    <= cfg_data_i;
        CfgReg5: cfg_q.reg5_word    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: clamp, classify, queue
  fnpll_front #(
    .FifoDepth(FifoDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .job_valid_o(job_valid),
    .job_ready_i(job_ready),
    .job_o      (job)
  );

  // Shared divider for the integer part, rounding, Euclid and reduction
  fnpll_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Back: sequence the math and send the words
  fnpll_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job),
    .div_req_o  (div_req),
    .div_rsp_i  (div_rsp),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  // After the final word leaves, the back end goes idle and the result channel goes empty
  a_last_then_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && result_o.last_word |=> empty)
    else $error("result offered right after the final word");

  // Queued jobs always carry a legal exponent
  a_expo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> (job.expo >= ExpoW'(1) && job.expo <= ExpoW'(ExpoMax)))
    else $error("divider exponent out of range");

  // A division never completes in the cycle after it starts
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> !div_rsp.done)
    else $error("divider finished too early");

  // Results are only offered when no division is under way at its start
  a_emit_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !div_req.start)
    else $error("division started while words are offered");

endmodule

// ===== dv/tb_top.sv =====
// Testbench: drives frequency requests and register writes, checks every result beat.
`timescale 1ns / 1ps
module tb_top;
  import fnpll_pkg::*;

  // Run control
  localparam int unsigned WatchdogLimit = 5000;  // cycles with no beat moving anywhere
  localparam int unsigned PhaseGap      = 16;    // quiet cycles before a register write
  localparam int unsigned TailCycles    = 600;   // quiet cycles at the end, after the last word
  localparam int unsigned SegItems      = 20;    // frequency requests per random segment
  localparam int unsigned NumSegs       = 8;     // two register settings per idling mode

  // Indexes past the last register; the block must drop these writes.
  localparam logic [2:0] CfgSpare5 = 3'd5;
  localparam logic [2:0] CfgSpare6 = 3'd6;
  localparam logic [2:0] CfgSpare7 = 3'd7;

  // Words that fall straight out of the formulas.
  localparam logic [31:0] Reg4Expo1  = 32'h009C_803C;  // divider exponent 1
  localparam logic [31:0] Reg4Expo16 = 32'h018C_803C;  // exponent 16 spills into bit 24
  localparam logic [31:0] Reg1Mod2   = 32'h0800_8011;  // modulus forced to 2

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    item_i;
  logic        empty;
  logic        pop;
  out_item_t   result_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  // Shadow copy of the configuration registers, loaded with the reset values.
  logic [7:0]  pfd_sh     = 8'd25;
  logic [15:0] modbase_sh = 16'd25000;
  logic [31:0] reg2_sh    = 32'h0000_4E42;
  logic [31:0] reg3_sh    = 32'h0000_04B3;
  logic [31:0] reg5_sh    = 32'h0058_0005;

  // Directed plan: a row is either a register write or a frequency request. On a typed
  // request the reg4, reg1 and reg0 words are given by hand instead of predicted.
  typedef struct packed {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [1:0]  ch;
    logic [31:0] data;
    bit          typed;
    logic [31:0] w4;
    logic [31:0] w1;
    logic [31:0] w0;
  } plan_row_t;

  plan_row_t   plan_q[$];
  out_item_t   word_q[$];      // register words still owed by the block, oldest first
  out_item_t   want;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned idle_cycles = 0;
  int          n_fail = 0;
  int          items_sent = 0;
  int          beats_checked = 0;
  int          cfg_writes = 0;

  frac_n_pll_register_calc_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Compute the reg4, reg1 and reg0 words for one frequency under the shadow settings.
  function automatic void pll_words(input logic [23:0] fin, output logic [31:0] w4,
                                    output logic [31:0] w1, output logic [31:0] w0);
    longint unsigned f, num, den, nint, rem, nfrac, mb, a, b, r;
    int unsigned     expo;
    logic [31:0]     frac, modv;
    f = fin;
    if (f > FreqMaxKhz) f = FreqMaxKhz;
    if (f < FreqMinKhz) f = FreqMinKhz;
    // smallest exponent of at least 1 that pushes f * 2^(i+1) past the ceiling
    expo = 1;
    while ((f << (expo + 1)) <= FreqMaxKhz) expo++;
    num   = f << expo;
    den   = ((pfd_sh == 8'd0) ? 64'd1 : 64'(pfd_sh)) * 64'd1000;
    nint  = num / den;
    rem   = num % den;
    mb    = modbase_sh;
    // round half up: floor((2*mb*rem + den) / (2*den))
    nfrac = (64'd2 * mb * rem + den) / (64'd2 * den);
    if (nfrac == 0) begin
      frac = 32'd0;
      modv = 32'd2;
    end else begin
      a = mb;
      b = nfrac;
      r = a % b;
      while (r != 0) begin
        a = b;
        b = r;
        r = a % b;
      end
      frac = 32'(nfrac / b);
      modv = 32'(mb / b);
      if (modv == 32'd1) modv = 32'd2;
    end
    w0 = (32'(nint) << 15) + (frac << 3);
    w1 = (32'd1 << 27) + (32'd1 << 15) + (modv << 3) + 32'd1;
    w4 = (32'd1 << 23) + (32'(expo) << 20) + (32'd200 << 12) + (32'd1 << 5)
         + (32'd3 << 3) + 32'd4;
  endfunction

  // Append the six words of one request in send order: reg5, reg4, reg3, reg2, reg1, reg0.
  function automatic void queue_words(input logic [1:0] ch, input logic [31:0] w4,
                                      input logic [31:0] w1, input logic [31:0] w0);
    logic [31:0] words [6];
    out_item_t   beat;
    words[BeatReg5] = reg5_sh;
    words[BeatReg4] = w4;
    words[BeatReg3] = reg3_sh;
    words[BeatReg2] = reg2_sh;
    words[BeatReg1] = w1;
    words[BeatReg0] = w0;
    for (int k = 0; k < 6; k++) begin
      beat.target_channel = ch;
      beat.reg_word       = words[k];
      beat.last_word      = (k == int'(BeatReg0));
      word_q.push_back(beat);
    end
  endfunction

  function automatic void add_cfg(input logic [2:0] idx, input logic [31:0] data);
    plan_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    plan_q.push_back(r);
  endfunction

  function automatic void add_item(input logic [1:0] ch, input logic [23:0] f,
                                   input bit typed, input logic [31:0] w4,
                                   input logic [31:0] w1, input logic [31:0] w0);
    plan_row_t r;
    r       = '0;
    r.ch    = ch;
    r.data  = 32'(f);
    r.typed = typed;
    r.w4    = w4;
    r.w1    = w1;
    r.w0    = w0;
    plan_q.push_back(r);
  endfunction

  // Mix of frequencies: raw 24-bit values, octave edges, the floor, and a log-like spread.
  function automatic logic [23:0] pick_freq();
    logic [23:0] f;
    case ($urandom_range(9))
      0:       f = 24'($urandom);
      1:       f = 24'((FreqMaxKhz >> $urandom_range(17)) + $urandom_range(2) - 1);
      2:       f = 24'($urandom_range(40));
      default: f = 24'($urandom_range(FreqMaxKhz) >> $urandom_range(16));
    endcase
    return f;
  endfunction

  // Enter at a falling edge; leave at the falling edge after the accepting rising edge,
  // with push still high so the next beat can follow back to back.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < snd_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Same timing as send_item; valid stays high so writes can run back to back.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgPfd:  pfd_sh     = data[7:0];
      CfgMod:  modbase_sh = data[15:0];
      CfgReg2: reg2_sh    = data;
      CfgReg3: reg3_sh    = data;
      CfgReg5: reg5_sh    = data;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // Drop push, wait for every owed word to come out, then hold quiet for gap cycles.
  task automatic settle(input int unsigned gap);
    push <= 1'b0;
    while (word_q.size() != 0) @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
  endtask

  // Receiver: decide pop for the next rising edge at every falling edge.
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      pop <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Check each popped beat against the oldest owed word, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (word_q.size() == 0) begin
        $error("result beat with nothing owed: target_channel %0d reg_word %h last_word %0b",
               result_o.target_channel, result_o.reg_word, result_o.last_word);
        n_fail++;
      end else begin
        want = word_q.pop_front();
        if (result_o.target_channel !== want.target_channel) begin
          $error("target_channel: expected %0d, got %0d",
                 want.target_channel, result_o.target_channel);
          n_fail++;
        end
        if (result_o.reg_word !== want.reg_word) begin
          $error("reg_word: expected %h, got %h", want.reg_word, result_o.reg_word);
          n_fail++;
        end
        if (result_o.last_word !== want.last_word) begin
          $error("last_word: expected %0b, got %0b", want.last_word, result_o.last_word);
          n_fail++;
        end
        beats_checked++;
      end
    end
  end

  // Watchdog: any beat on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_item_t    it;
    logic [31:0] cfg_word;
    logic [31:0] w4, w1, w0;
    bit          cfg_open;

    push        = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgPfd;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    cfg_open    = 1'b0;

    // Reset settings: field extremes, clamping on both sides, octave edges.
    add_item(2'd0, 24'd0,        1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd1, 24'd34,       1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd2, 24'd35,       1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd3, 24'd36,       1'b0, 32'd0, 32'd0, 32'd0);
    // top of the range divides evenly by 25 MHz: zero fraction, integer 352
    add_item(2'd1, 24'd4400000,  1'b1, Reg4Expo1, Reg1Mod2, 32'h00B0_0000);
    add_item(2'd2, 24'd4400001,  1'b1, Reg4Expo1, Reg1Mod2, 32'h00B0_0000);
    add_item(2'd3, 24'hFF_FFFF,  1'b1, Reg4Expo1, Reg1Mod2, 32'h00B0_0000);
    add_item(2'd0, 24'd1100000,  1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd0, 24'd1100001,  1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd1, 24'h55_5555,  1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd2, 24'hAA_AAAA,  1'b0, 32'd0, 32'd0, 32'd0);
    // Zero reference (taken as 1 MHz) and a modulus of 2, plus writes to spare indexes.
    add_cfg(CfgPfd,    32'h0000_0000);
    add_cfg(CfgMod,    32'h0000_0002);
    add_cfg(CfgSpare5, 32'hFFFF_FFFF);
    add_cfg(CfgSpare7, 32'h0000_0000);
    // fraction rounds up to the full modulus: reduces to 1/1, modulus bumped to 2
    add_item(2'd3, 24'd35,       1'b1, Reg4Expo16, Reg1Mod2, 32'h047A_8008);
    add_item(2'd1, 24'd4400000,  1'b1, Reg4Expo1,  Reg1Mod2, 32'h1130_0000);
    add_item(2'd0, 24'd2749,     1'b0, 32'd0, 32'd0, 32'd0);
    // Upper extremes of every register but reg3, which goes to zero.
    add_cfg(CfgPfd,    32'h0000_00FF);
    add_cfg(CfgMod,    32'h0000_FFFF);
    add_cfg(CfgReg2,   32'hFFFF_FFFF);
    add_cfg(CfgReg3,   32'h0000_0000);
    add_cfg(CfgReg5,   32'hFFFF_FFFF);
    add_cfg(CfgSpare6, 32'h1234_5678);
    add_item(2'd2, 24'd123457,   1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd3, 24'd4400000,  1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd1, 24'd35,       1'b0, 32'd0, 32'd0, 32'd0);
    // Zero modulus base and junk above the reference and modulus widths.
    add_cfg(CfgMod,    32'hABCD_0000);
    add_cfg(CfgPfd,    32'hFFFF_FF01);
    add_cfg(CfgReg2,   32'h0000_0000);
    add_cfg(CfgReg3,   32'hFFFF_FFFF);
    add_cfg(CfgReg5,   32'h0000_0000);
    add_item(2'd0, 24'd999999,   1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd2, 24'd35,       1'b0, 32'd0, 32'd0, 32'd0);
    // Modulus base of 1.
    add_cfg(CfgMod,    32'h0000_0001);
    add_item(2'd3, 24'd3000000,  1'b0, 32'd0, 32'd0, 32'd0);
    add_item(2'd1, 24'd1234,     1'b0, 32'd0, 32'd0, 32'd0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the plan with no idling. Drain before the first write of each group.
    foreach (plan_q[k]) begin
      if (plan_q[k].is_cfg) begin
        if (!cfg_open) settle(PhaseGap);
        write_reg(plan_q[k].idx, plan_q[k].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid_i <= 1'b0;
        cfg_open          = 1'b0;
        it.channel        = plan_q[k].ch;
        it.freq_khz       = plan_q[k].data[23:0];
        send_item(it);
        if (plan_q[k].typed) begin
          queue_words(it.channel, plan_q[k].w4, plan_q[k].w1, plan_q[k].w0);
        end else begin
          pll_words(it.freq_khz, w4, w1, w0);
          queue_words(it.channel, w4, w1, w0);
        end
      end
    end

    // Random segments: each idling mode runs under two fresh register settings.
    for (int seg = 0; seg < NumSegs; seg++) begin
      settle(PhaseGap);
      case (seg / 2)
        0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1:       begin snd_idle_pct = 66; rcv_stall_pct = 0;  end
        2:       begin snd_idle_pct = 0;  rcv_stall_pct = 66; end
        default: begin snd_idle_pct = 31; rcv_stall_pct = 31; end
      endcase
      // junk above the register's width rides along in the reference and modulus writes
      cfg_word = $urandom;
      case ($urandom_range(7))
        0:       cfg_word[7:0] = 8'd0;
        1:       cfg_word[7:0] = 8'd1;
        2:       cfg_word[7:0] = 8'd255;
        default: cfg_word[7:0] = 8'($urandom_range(100, 10));
      endcase
      write_reg(CfgPfd, cfg_word);
      cfg_word = $urandom;
      case ($urandom_range(7))
        0:       cfg_word[15:0] = 16'd0;
        1:       cfg_word[15:0] = 16'd1;
        2:       cfg_word[15:0] = 16'd2;
        3:       cfg_word[15:0] = 16'hFFFF;
        4:       cfg_word[15:0] = 16'($urandom_range(16, 2));
        default: cfg_word[15:0] = 16'($urandom_range(65535, 2));
      endcase
      write_reg(CfgMod, cfg_word);
      write_reg(CfgReg2, $urandom);
      write_reg(CfgReg3, $urandom);
      write_reg(CfgReg5, $urandom);
      case ($urandom_range(3))
        0:       write_reg(CfgSpare5, $urandom);
        1:       write_reg(CfgSpare6, $urandom);
        2:       write_reg(CfgSpare7, $urandom);
        default: ;
      endcase
      cfg_valid_i <= 1'b0;
      repeat (SegItems) begin
        it.channel  = 2'($urandom_range(3));
        it.freq_khz = pick_freq();
        send_item(it);
        pll_words(it.freq_khz, w4, w1, w0);
        queue_words(it.channel, w4, w1, w0);
      end
    end

    settle(TailCycles);
    $display("Covered %0d frequency requests and %0d register writes in four idling modes;",
             items_sent, cfg_writes);
    $display("checked %0d result beats, %0d mismatches.", beats_checked, n_fail);
    if (n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
